// ===== rtl/nsml_pkg.sv =====
// ----------------------------------------------------------------------------
// nsml_pkg
// Shared widths, action codes and the search key type for the nearest seed
// Manhattan labeler.
// ----------------------------------------------------------------------------
package nsml_pkg;

    localparam int COORD_W       = 10;
    localparam int DIST_W        = 11;
    localparam int SLOT_W        = 6;
    localparam int REGION_W      = 6;
    localparam int COUNT_W       = 7;
    localparam int MAX_SEEDS_DEF = 64;

    localparam logic ACT_LOAD     = 1'b0;
    localparam logic ACT_CLASSIFY = 1'b1;

    // inactive lanes sort above every real distance
    typedef struct packed {
        logic              inactive;
        logic [DIST_W-1:0] dval;
    } key_t;

endpackage

// ===== rtl/nearest_seed_manhattan_labeler_top.sv =====
// ----------------------------------------------------------------------------
// nearest_seed_manhattan_labeler_top
// Labels a point with the nearest loaded seed (Manhattan distance, lowest
// index on ties); load transactions write the seed table.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+-----------------------------------
//  input    | start, busy             | action, seed_index, row, col
//  result   | done (one-cycle strobe) | region, distance
//  config   | seed_count_we           | seed_count_wdata
//
//  A new transaction is taken every clock; busy is always low.
//  A classify goes through the registered per-seed distance lanes, then
//  through one register per level of the minimum tree.
//  Loads write the seed registers at acceptance and give no result.
//  Reset clears seed_count to 1 and the pipeline valids; seed table is not
//  cleared. The result side has no backpressure, so nothing ever stalls.
// ----------------------------------------------------------------------------
module nearest_seed_manhattan_labeler_top
    import nsml_pkg::*;
#(
    parameter int MAX_SEEDS = MAX_SEEDS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                action,
    input  logic [SLOT_W-1:0]   seed_index,
    input  logic [COORD_W-1:0]  row,
    input  logic [COORD_W-1:0]  col,
    output logic                done,
    output logic [REGION_W-1:0] region,
    output logic [DIST_W-1:0]   distance,
    input  logic                seed_count_we,
    input  logic [COUNT_W-1:0]  seed_count_wdata
);

    localparam int IDX_W = $clog2(MAX_SEEDS);
    localparam int CNT_W = $clog2(MAX_SEEDS + 1);
    localparam int LAT   = 1 + IDX_W;

    logic [COUNT_W-1:0] seed_count_reg;
    logic [CNT_W-1:0]   active_cnt;
    logic               accept;

    logic [COORD_W-1:0] seed_row_reg [MAX_SEEDS];
    logic [COORD_W-1:0] seed_col_reg [MAX_SEEDS];
    key_t               lane_next    [MAX_SEEDS];
    key_t               lane_key_reg [MAX_SEEDS];
    logic               lane_vld_reg;

    logic               root_vld;
    logic [IDX_W-1:0]   root_idx;
    key_t               root_key;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_count_reg <= COUNT_W'(1);
        end
        else if (seed_count_we)
        begin
            seed_count_reg <= seed_count_wdata;
        end
    end

    // zero means one seed, large counts saturate at the table size
    always_comb
    begin
        if (seed_count_reg == '0)
        begin
            active_cnt = CNT_W'(1);
        end
        else if (32'(seed_count_reg) > 32'(MAX_SEEDS))
        begin
            active_cnt = CNT_W'(MAX_SEEDS);
        end
        else
        begin
            active_cnt = CNT_W'(seed_count_reg);
        end
    end

    // slots beyond the table are never matched, so those loads drop out
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_SEEDS; i++)
        begin
            if (accept && action == ACT_LOAD && 32'(seed_index) == 32'(i))
            begin
                seed_row_reg[i] <= row;
                seed_col_reg[i] <= col;
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_SEEDS; g++) begin : g_lane
            logic [COORD_W-1:0] dr;
            logic [COORD_W-1:0] dc;

            assign dr = (row >= seed_row_reg[g]) ? row - seed_row_reg[g]
                                                 : seed_row_reg[g] - row;
            assign dc = (col >= seed_col_reg[g]) ? col - seed_col_reg[g]
                                                 : seed_col_reg[g] - col;
            assign lane_next[g].dval     = DIST_W'(dr) + DIST_W'(dc);
            assign lane_next[g].inactive = !(32'(g) < 32'(active_cnt));
        end
    endgenerate

    // distances come from the table as it stands at acceptance
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_SEEDS; i++)
        begin
            lane_key_reg[i] <= lane_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_vld_reg <= 1'b0;
        end
        else
        begin
            lane_vld_reg <= accept && action == ACT_CLASSIFY;
        end
    end

    nsml_min_tree #(
        .LANES    (MAX_SEEDS)
    ) u_min_tree (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (lane_vld_reg),
        .leaf_key (lane_key_reg),
        .out_vld  (root_vld),
        .out_idx  (root_idx),
        .out_key  (root_key)
    );

    assign done     = root_vld;
    assign region   = REGION_W'(root_idx);
    assign distance = root_key.dval;

    a_classify_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && action == ACT_CLASSIFY) |-> ##LAT done)
        else $error("classify transaction produced no result");

    a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && action == ACT_CLASSIFY, LAT))
        else $error("result without a classify transaction");

    a_winner_active: assert property (@(posedge clk) disable iff (!rst_n)
        root_vld |-> !root_key.inactive)
        else $error("winning lane is outside the active seed range");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_cnt != '0 && 32'(active_cnt) <= 32'(MAX_SEEDS))
        else $error("active seed count out of range");

endmodule

// ===== rtl/nsml_min_tree.sv =====
// ----------------------------------------------------------------------------
// nsml_min_tree
// Registered binary minimum tree, one tree level per clock. Ties keep the
// left (lower index) child.
// ----------------------------------------------------------------------------
module nsml_min_tree
    import nsml_pkg::*;
#(
    parameter int LANES = MAX_SEEDS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_vld,
    input  key_t                       leaf_key [LANES],
    output logic                       out_vld,
    output logic [$clog2(LANES)-1:0]   out_idx,
    output key_t                       out_key
);

    localparam int LEVELS = $clog2(LANES);
    localparam int P      = 1 << LEVELS;
    localparam int IDX_W  = LEVELS;

    key_t             leaf_w       [P];
    key_t             node_key_reg [1:P-1];
    logic [IDX_W-1:0] node_idx_reg [1:P-1];
    logic [LEVELS-1:0] vld_reg;

    genvar j, n;

    generate
        for (j = 0; j < P; j++) begin : g_leaf
            if (j < LANES) begin : g_real
                assign leaf_w[j] = leaf_key[j];
            end
            else begin : g_pad
                assign leaf_w[j] = '{inactive: 1'b1, dval: '0};
            end
        end

        for (n = 1; n < P; n++) begin : g_node
            key_t             lk;
            key_t             rk;
            logic [IDX_W-1:0] li;
            logic [IDX_W-1:0] ri;

            if (2 * n >= P) begin : g_from_leaf
                assign lk = leaf_w[2*n - P];
                assign rk = leaf_w[2*n + 1 - P];
                assign li = IDX_W'(2*n - P);
                assign ri = IDX_W'(2*n + 1 - P);
            end
            else begin : g_from_node
                assign lk = node_key_reg[2*n];
                assign rk = node_key_reg[2*n + 1];
                assign li = node_idx_reg[2*n];
                assign ri = node_idx_reg[2*n + 1];
            end

            always_ff @(posedge clk)
            begin
                if ({rk.inactive, rk.dval} < {lk.inactive, lk.dval})
                begin
                    node_key_reg[n] <= rk;
                    node_idx_reg[n] <= ri;
                end
                else
                begin
                    node_key_reg[n] <= lk;
                    node_idx_reg[n] <= li;
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= LEVELS'({vld_reg, in_vld});
        end
    end

    assign out_vld = vld_reg[LEVELS-1];
    assign out_idx = node_idx_reg[1];
    assign out_key = node_key_reg[1];

endmodule

// ===== bench/nearest_seed_manhattan_labeler_top_tb.sv =====
// ----------------------------------------------------------------------------
// nearest_seed_manhattan_labeler_top_tb
// Self-checking bench for the nearest seed labeler. A short directed table
// hits the coordinate extremes, ties, the seed_count reset value and the
// zero and above-table counts. A randomized part follows, with seed loads
// and point classifications in phases under several seed_count settings.
// Labels are checked against typed values or a nearest-seed search.
// ----------------------------------------------------------------------------
module nearest_seed_manhattan_labeler_top_tb;
    import nsml_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_LAT    = 1 + $clog2(MAX_SEEDS_DEF);
    localparam int TARGET_ITEMS = 650;
    localparam int COORD_MAX   = (1 << COORD_W) - 1;

    typedef struct packed {
        logic [REGION_W-1:0] region;
        logic [DIST_W-1:0]   dval;
    } label_t;

    typedef enum {ROW_LOAD, ROW_POINT, ROW_COUNT} row_kind_t;

    typedef struct {
        row_kind_t kind;
        int        arg;     // slot for a load, value for a count write
        int        r;
        int        c;
        bit        typed;
        int        exp_region;
        int        exp_dist;
    } plan_row_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                action;
    logic [SLOT_W-1:0]   seed_index;
    logic [COORD_W-1:0]  row;
    logic [COORD_W-1:0]  col;
    logic                done;
    logic [REGION_W-1:0] region;
    logic [DIST_W-1:0]   distance;
    logic                seed_count_we;
    logic [COUNT_W-1:0]  seed_count_wdata;

    // shadow of the block's state
    logic [COORD_W-1:0]  seed_row_tab [MAX_SEEDS_DEF];
    logic [COORD_W-1:0]  seed_col_tab [MAX_SEEDS_DEF];
    bit                  seed_loaded  [MAX_SEEDS_DEF];
    logic [COUNT_W-1:0]  count_reg;

    label_t    pending_labels [$];
    plan_row_t plan [$];

    int mismatch_count;
    int labels_seen;
    int points_sent;
    int loads_sent;
    int count_writes;
    bit quiet;

    nearest_seed_manhattan_labeler_top dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .action           (action),
        .seed_index       (seed_index),
        .row              (row),
        .col              (col),
        .done             (done),
        .region           (region),
        .distance         (distance),
        .seed_count_we    (seed_count_we),
        .seed_count_wdata (seed_count_wdata)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    initial
    begin
        #5_000_000;
        $display("nearest_seed_manhattan_labeler_top_tb: errors");
        $finish;
    end

    function automatic int active_count();
        if (count_reg == 0)
            return 1;
        if (count_reg > MAX_SEEDS_DEF)
            return MAX_SEEDS_DEF;
        return int'(count_reg);
    endfunction

    function automatic int abs_diff(input int a, input int b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function automatic label_t nearest_seed(input logic [COORD_W-1:0] r,
                                            input logic [COORD_W-1:0] c);
        label_t best;
        int     best_d;
        int     d;
        best_d = abs_diff(r, seed_row_tab[0]) + abs_diff(c, seed_col_tab[0]);
        best.region = '0;
        for (int i = 1; i < active_count(); i++)
        begin
            d = abs_diff(r, seed_row_tab[i]) + abs_diff(c, seed_col_tab[i]);
            if (d < best_d)
            begin
                best_d = d;
                best.region = REGION_W'(i);
            end
        end
        best.dval = DIST_W'(best_d);
        return best;
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return COORD_W'(COORD_MAX);
            default: return COORD_W'($urandom_range(0, COORD_MAX));
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] nudge(input logic [COORD_W-1:0] v);
        int n;
        n = int'(v) + $urandom_range(0, 8) - 4;
        if (n < 0)
            n = 0;
        if (n > COORD_MAX)
            n = COORD_MAX;
        return COORD_W'(n);
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at %0t: %s got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        label_t want;
        if (rst_n && done)
        begin
            labels_seen++;
            if (pending_labels.size() == 0)
                flag_mismatch("unexpected label, region", region, -1);
            else
            begin
                want = pending_labels.pop_front();
                if (region !== want.region)
                    flag_mismatch("region", region, want.region);
                if (distance !== want.dval)
                    flag_mismatch("distance", distance, want.dval);
            end
        end
    end

    task automatic maybe_idle();
        if (!quiet && $urandom_range(0, 99) < 7)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
    endtask

    // one transaction; the label is predicted at acceptance
    task automatic send_item(input logic act, input logic [SLOT_W-1:0] slot,
                             input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] c,
                             input bit typed, input label_t typed_label);
        start      <= 1'b1;
        action     <= act;
        seed_index <= slot;
        row        <= r;
        col        <= c;
        do
            @(posedge clk);
        while (busy);
        if (act == ACT_LOAD)
        begin
            seed_row_tab[slot] = r;
            seed_col_tab[slot] = c;
            seed_loaded[slot]  = 1'b1;
            loads_sent++;
        end
        else
        begin
            pending_labels.push_back(typed ? typed_label : nearest_seed(r, c));
            points_sent++;
        end
        maybe_idle();
    endtask

    // a classify must never read a slot that was never loaded
    task automatic load_missing();
        for (int i = 0; i < active_count(); i++)
            if (!seed_loaded[i])
                send_item(ACT_LOAD, SLOT_W'(i), rand_coord(), rand_coord(), 1'b0, '0);
    endtask

    task automatic drain_pending();
        start <= 1'b0;
        @(posedge clk);
        while (pending_labels.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_seed_count(input int value);
        drain_pending();
        repeat (PIPE_LAT + 2) @(posedge clk);
        seed_count_we    <= 1'b1;
        seed_count_wdata <= COUNT_W'(value);
        @(posedge clk);
        count_reg = COUNT_W'(value);
        count_writes++;
        seed_count_we <= 1'b0;
    endtask

    function automatic void add_row(input row_kind_t kind, input int arg, input int r,
                                    input int c, input bit typed = 1'b0,
                                    input int exp_region = 0, input int exp_dist = 0);
        plan.push_back('{kind, arg, r, c, typed, exp_region, exp_dist});
    endfunction

    function automatic int pick_count();
        case ($urandom_range(0, 9))
            0:       return 1;
            1:       return MAX_SEEDS_DEF;
            2:       return 0;
            3:       return $urandom_range(MAX_SEEDS_DEF + 1, (1 << COUNT_W) - 1);
            4:       return (1 << COUNT_W) - 1;
            5:       return $urandom_range(2, 4);
            default: return $urandom_range(1, MAX_SEEDS_DEF);
        endcase
    endfunction

    initial
    begin
        label_t             lbl;
        int                 phase_len;
        int                 j;
        logic [COORD_W-1:0] r;
        logic [COORD_W-1:0] c;

        rst_n            <= 1'b0;
        start            <= 1'b0;
        action           <= ACT_LOAD;
        seed_index       <= '0;
        row              <= '0;
        col              <= '0;
        seed_count_we    <= 1'b0;
        seed_count_wdata <= '0;
        count_reg         = 1;
        quiet             = 1'b0;
        for (int i = 0; i < MAX_SEEDS_DEF; i++)
            seed_loaded[i] = 1'b0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part; seed_count is still at its reset value of 1
        add_row(ROW_LOAD, 0, 0, 0);
        add_row(ROW_POINT, 0, 0, 0, 1'b1, 0, 0);
        add_row(ROW_POINT, 0, 1023, 1023, 1'b1, 0, 2046);
        add_row(ROW_LOAD, 1, 1023, 1023);
        add_row(ROW_POINT, 0, 1023, 1023, 1'b1, 0, 2046);
        add_row(ROW_COUNT, 2, 0, 0);
        add_row(ROW_POINT, 0, 1023, 1023, 1'b1, 1, 0);
        add_row(ROW_POINT, 0, 511, 512, 1'b1, 0, 1023);     // tie, lower index
        add_row(ROW_POINT, 0, 1023, 0, 1'b1, 0, 1023);
        add_row(ROW_COUNT, 0, 0, 0);                        // zero acts as one
        add_row(ROW_POINT, 0, 1023, 1023, 1'b1, 0, 2046);
        add_row(ROW_LOAD, 63, 1023, 0);
        add_row(ROW_LOAD, 2, 1023, 1023);
        add_row(ROW_COUNT, 64, 0, 0);
        add_row(ROW_POINT, 0, 1023, 0);
        add_row(ROW_POINT, 0, 1023, 1023, 1'b1, 1, 0);
        add_row(ROW_COUNT, 127, 0, 0);                      // saturates at table size
        add_row(ROW_POINT, 0, 800, 600);
        add_row(ROW_POINT, 0, 0, 1023);
        add_row(ROW_COUNT, 65, 0, 0);
        add_row(ROW_POINT, 0, 300, 700);
        add_row(ROW_LOAD, 0, 512, 512);
        add_row(ROW_POINT, 0, 512, 512, 1'b1, 0, 0);

        foreach (plan[k])
        begin
            case (plan[k].kind)
                ROW_LOAD:
                    send_item(ACT_LOAD, SLOT_W'(plan[k].arg), COORD_W'(plan[k].r),
                              COORD_W'(plan[k].c), 1'b0, '0);
                ROW_COUNT:
                    write_seed_count(plan[k].arg);
                default:
                begin
                    load_missing();
                    lbl.region = REGION_W'(plan[k].exp_region);
                    lbl.dval   = DIST_W'(plan[k].exp_dist);
                    send_item(ACT_CLASSIFY, SLOT_W'($urandom_range(0, 63)),
                              COORD_W'(plan[k].r), COORD_W'(plan[k].c),
                              plan[k].typed, lbl);
                end
            endcase
        end

        // randomized phases, one seed_count setting each
        while (loads_sent + points_sent < TARGET_ITEMS)
        begin
            write_seed_count(pick_count());
            phase_len = $urandom_range(30, 70);
            for (int k = 0; k < phase_len; k++)
            begin
                quiet = (loads_sent + points_sent >= 250) && (loads_sent + points_sent < 400);
                if ($urandom_range(0, 59) == 0)
                    drain_pending();
                if ($urandom_range(0, 9) < 3)
                begin
                    j = $urandom_range(0, MAX_SEEDS_DEF - 1);
                    if ($urandom_range(0, 4) == 0 && seed_loaded[j])
                    begin
                        // duplicate an existing seed to provoke ties
                        r = seed_row_tab[j];
                        c = seed_col_tab[j];
                    end
                    else
                    begin
                        r = rand_coord();
                        c = rand_coord();
                    end
                    send_item(ACT_LOAD, SLOT_W'($urandom_range(0, MAX_SEEDS_DEF - 1)),
                              r, c, 1'b0, '0);
                end
                else
                begin
                    load_missing();
                    if ($urandom_range(0, 2) == 0)
                    begin
                        j = $urandom_range(0, active_count() - 1);
                        r = nudge(seed_row_tab[j]);
                        c = nudge(seed_col_tab[j]);
                    end
                    else
                    begin
                        r = rand_coord();
                        c = rand_coord();
                    end
                    send_item(ACT_CLASSIFY, SLOT_W'($urandom_range(0, 63)), r, c, 1'b0, '0);
                end
            end
        end

        drain_pending();
        repeat (PIPE_LAT + 4) @(posedge clk);

        $display("covered %0d seed loads and %0d classified points over %0d seed_count writes",
                 loads_sent, points_sent, count_writes);
        $display("%0d labels checked, %0d mismatches", labels_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("nearest_seed_manhattan_labeler_top_tb: clean");
        else
            $display("nearest_seed_manhattan_labeler_top_tb: errors");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/nsml_pkg.sv
rtl/nsml_min_tree.sv
rtl/nearest_seed_manhattan_labeler_top.sv
bench/nearest_seed_manhattan_labeler_top_tb.sv
